[hdl/ddd_pkg.sv]
// Shared types, constants and calendar tables for the date difference block.
`default_nettype none

package ddd_pkg;

    localparam int DAY_BITS          = 5;
    localparam int MONTH_BITS        = 4;
    localparam int YEAR_BITS_DEFAULT = 12;
    localparam int YEAR_BITS_MAX     = 16;
    localparam int COUNT_BITS        = 21;
    localparam int STATUS_BITS       = 2;
    localparam int DOY_BITS          = 9;
    localparam int MOD_BITS          = 5;

    localparam int DAYS_PER_YEAR = 365;
    localparam int LEAP_DIVISOR  = 25;
    localparam int MONTHS        = 12;
    localparam int FEBRUARY      = 2;

    // floor(y / 25) = (y * ceil(2^21 / 25)) >> 21 for every year below 2^16
    localparam int MOD25_SHIFT     = 21;
    localparam int MOD25_RECIP     = 83887;
    localparam int MOD25_PROD_BITS = 2 * YEAR_BITS_MAX + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ORDER   = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef struct packed {
        logic                ok;
        logic [DOY_BITS-1:0] doy;
    } date_eval_t;

    // leap when divisible by 4, and by 400 whenever divisible by 100
    function automatic logic is_leap(input logic [3:0] year_low,
                                     input logic [MOD_BITS-1:0] mod25);
        return (year_low[1:0] == 2'd0) && ((mod25 != '0) || (year_low == 4'd0));
    endfunction

    function automatic logic [MOD_BITS-1:0] year_mod25(input logic [YEAR_BITS_MAX-1:0] year);
        logic [MOD25_PROD_BITS-1:0] prod;
        logic [YEAR_BITS_MAX-1:0]   quot;
        logic [YEAR_BITS_MAX-1:0]   rem;
        prod = MOD25_PROD_BITS'(year) * MOD25_PROD_BITS'(MOD25_RECIP);
        quot = YEAR_BITS_MAX'(prod >> MOD25_SHIFT);
        rem  = year - quot * YEAR_BITS_MAX'(LEAP_DIVISOR);
        return rem[MOD_BITS-1:0];
    endfunction

    function automatic logic [DOY_BITS-1:0] month_start(input logic [MONTH_BITS-1:0] month);
        logic [DOY_BITS-1:0] start;
        unique case (month)
            4'd1:    start = 9'd0;
            4'd2:    start = 9'd31;
            4'd3:    start = 9'd59;
            4'd4:    start = 9'd90;
            4'd5:    start = 9'd120;
            4'd6:    start = 9'd151;
            4'd7:    start = 9'd181;
            4'd8:    start = 9'd212;
            4'd9:    start = 9'd243;
            4'd10:   start = 9'd273;
            4'd11:   start = 9'd304;
            4'd12:   start = 9'd334;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] month,
                                                      input logic leap);
        logic [DAY_BITS-1:0] len;
        unique case (month)
            4'd2:                       len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[hdl/ddd_in_if.sv]
// Input channel carrying one pair of dates per item.
`default_nettype none

interface ddd_in_if
    import ddd_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [DAY_BITS-1:0]   earlier_day;
    logic [MONTH_BITS-1:0] earlier_month;
    logic [YEAR_BITS-1:0]  earlier_year;
    logic [DAY_BITS-1:0]   later_day;
    logic [MONTH_BITS-1:0] later_month;
    logic [YEAR_BITS-1:0]  later_year;

    modport source (
        output valid, earlier_day, earlier_month, earlier_year,
               later_day, later_month, later_year,
        input  ready
    );

    modport sink (
        input  valid, earlier_day, earlier_month, earlier_year,
               later_day, later_month, later_year,
        output ready
    );
endinterface

`default_nettype wire

[hdl/ddd_out_if.sv]
// Output channel carrying one day count and status per item.
`default_nettype none

interface ddd_out_if
    import ddd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] day_count;
    status_t               status;

    modport source (
        output valid, day_count, status,
        input  ready
    );

    modport sink (
        input  valid, day_count, status,
        output ready
    );
endinterface

`default_nettype wire

[hdl/date_difference_days.sv]
// Gregorian day difference between two dates, computed on one shared adder.
//
// Each item passes from acceptance through S_MOD_E, S_MOD_L, S_CHECK, S_YEARS,
// S_FINISH and S_OUTPUT to a result in the output register, skipping S_YEARS
// and S_FINISH when a date is invalid or the dates are out of order. The
// remainder of each year modulo 25, which the leap rule needs, comes from one
// reciprocal multiplier used in states S_MOD_E and S_MOD_L (earlier year, then
// later year); the count then walks one year per cycle from the earlier year to
// the later year through the adder, which sets the item time. The input is
// ready only while no item is in progress; a finished result waits in the
// output register without blocking the next item, and the following result
// holds the sequencer until that register is taken. The day count saturates
// at its maximum value; errors give a count of 0.
`default_nettype none

module date_difference_days
    import ddd_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEFAULT
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ddd_in_if.sink     req,
    ddd_out_if.source  rsp
);

    localparam int ACC_BITS = (YEAR_BITS + 10 > COUNT_BITS) ? YEAR_BITS + 10 : COUNT_BITS + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD_E,
        S_MOD_L,
        S_CHECK,
        S_YEARS,
        S_FINISH,
        S_OUTPUT
    } state_t;

    state_t                state_reg,      state_next;
    logic [DAY_BITS-1:0]   ed_reg,         ed_next;
    logic [MONTH_BITS-1:0] em_reg,         em_next;
    logic [YEAR_BITS-1:0]  ey_reg,         ey_next;
    logic [DAY_BITS-1:0]   ld_reg,         ld_next;
    logic [MONTH_BITS-1:0] lm_reg,         lm_next;
    logic [YEAR_BITS-1:0]  ly_reg,         ly_next;
    logic [MOD_BITS-1:0]   mod_reg,        mod_next;
    logic [MOD_BITS-1:0]   mod_e_reg,      mod_e_next;
    logic [YEAR_BITS-1:0]  year_reg,       year_next;
    logic [ACC_BITS-1:0]   acc_reg,        acc_next;
    status_t               status_reg,     status_next;
    logic                  out_valid_reg,  out_valid_next;
    logic [COUNT_BITS-1:0] out_count_reg,  out_count_next;
    status_t               out_status_reg, out_status_next;

    logic                  leap_e;
    logic                  leap_l;
    logic                  leap_y;
    date_eval_t            eval_e;
    date_eval_t            eval_l;
    logic                  invalid;
    logic                  order_bad;
    logic [YEAR_BITS-1:0]  mod_src;
    logic [MOD_BITS-1:0]   mod_val;
    logic                  out_free;

    logic [ACC_BITS-1:0]   alu_a;
    logic [ACC_BITS-1:0]   alu_b;
    logic                  alu_sub;
    logic [ACC_BITS-1:0]   alu_res;

    assign leap_e = is_leap(ey_reg[3:0], mod_e_reg);
    assign leap_l = is_leap(ly_reg[3:0], mod_reg);
    assign leap_y = is_leap(year_reg[3:0], mod_reg);

    ddd_date_eval u_eval_e (
        .day    (ed_reg),
        .month  (em_reg),
        .leap   (leap_e),
        .result (eval_e)
    );

    ddd_date_eval u_eval_l (
        .day    (ld_reg),
        .month  (lm_reg),
        .leap   (leap_l),
        .result (eval_l)
    );

    assign invalid   = !eval_e.ok || !eval_l.ok || (ey_reg == '0) || (ly_reg == '0);
    assign order_bad = (ey_reg > ly_reg)
                    || ((ey_reg == ly_reg) && ((em_reg > lm_reg)
                    || ((em_reg == lm_reg) && (ed_reg > ld_reg))));

    assign mod_src  = (state_reg == S_MOD_E) ? ey_reg : ly_reg;
    assign mod_val  = year_mod25(YEAR_BITS_MAX'(mod_src));
    assign out_free = !out_valid_reg || rsp.ready;

    // shared adder/subtractor
    always_comb
    begin
        unique case (state_reg)
            S_YEARS:
            begin
                alu_a   = acc_reg;
                alu_b   = leap_y ? ACC_BITS'(DAYS_PER_YEAR + 1) : ACC_BITS'(DAYS_PER_YEAR);
                alu_sub = 1'b0;
            end
            S_FINISH:
            begin
                alu_a   = acc_reg;
                alu_b   = ACC_BITS'(eval_e.doy);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
        alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    always_comb
    begin
        state_next      = state_reg;
        ed_next         = ed_reg;
        em_next         = em_reg;
        ey_next         = ey_reg;
        ld_next         = ld_reg;
        lm_next         = lm_reg;
        ly_next         = ly_reg;
        mod_next        = mod_reg;
        mod_e_next      = mod_e_reg;
        year_next       = year_reg;
        acc_next        = acc_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    ed_next    = req.earlier_day;
                    em_next    = req.earlier_month;
                    ey_next    = req.earlier_year;
                    ld_next    = req.later_day;
                    lm_next    = req.later_month;
                    ly_next    = req.later_year;
                    state_next = S_MOD_E;
                end
            end
            S_MOD_E:
            begin
                mod_e_next = mod_val;
                state_next = S_MOD_L;
            end
            S_MOD_L:
            begin
                mod_next   = mod_val;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                year_next = ey_reg;
                mod_next  = mod_e_reg;
                acc_next  = ACC_BITS'(eval_l.doy);
                if (invalid)
                begin
                    status_next = STATUS_INVALID;
                    acc_next    = '0;
                    state_next  = S_OUTPUT;
                end
                else if (order_bad)
                begin
                    status_next = STATUS_ORDER;
                    acc_next    = '0;
                    state_next  = S_OUTPUT;
                end
                else
                begin
                    status_next = STATUS_OK;
                    state_next  = S_YEARS;
                end
            end
            S_YEARS:
            begin
                if (year_reg == ly_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    acc_next  = alu_res;
                    year_next = year_reg + YEAR_BITS'(1);
                    mod_next  = (mod_reg == MOD_BITS'(LEAP_DIVISOR - 1))
                                ? '0 : mod_reg + MOD_BITS'(1);
                end
            end
            S_FINISH:
            begin
                acc_next   = alu_res;
                state_next = S_OUTPUT;
            end
            S_OUTPUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_count_next  = (acc_reg > ACC_BITS'(COUNT_MAX))
                                      ? COUNT_MAX : acc_reg[COUNT_BITS-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ed_reg         <= ed_next;
        em_reg         <= em_next;
        ey_reg         <= ey_next;
        ld_reg         <= ld_next;
        lm_reg         <= lm_next;
        ly_reg         <= ly_next;
        mod_reg        <= mod_next;
        mod_e_reg      <= mod_e_next;
        year_reg       <= year_next;
        acc_reg        <= acc_next;
        status_reg     <= status_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.day_count = out_count_reg;
    assign rsp.status    = out_status_reg;

endmodule

`default_nettype wire

[hdl/ddd_date_eval.sv]
// Date check and day-of-year offset for one date, given its leap flag.
`default_nettype none

module ddd_date_eval
    import ddd_pkg::*;
(
    input  wire logic [DAY_BITS-1:0]   day,
    input  wire logic [MONTH_BITS-1:0] month,
    input  wire logic                  leap,
    output date_eval_t                 result
);

    logic month_ok;
    logic leap_adj;

    assign month_ok = (month != '0) && (month <= MONTH_BITS'(MONTHS));
    assign leap_adj = leap && (month > MONTH_BITS'(FEBRUARY));

    assign result.ok  = month_ok && (day != '0) && (day <= month_len(month, leap));
    assign result.doy = month_start(month) + DOY_BITS'(leap_adj) + DOY_BITS'(day)
                        - DOY_BITS'(1);

endmodule

`default_nettype wire

[tb/date_difference_days_test.sv]
// Testbench for the Gregorian day difference block: directed and random date pairs.
`default_nettype none

module date_difference_days_test
    import ddd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int YEAR_BITS  = YEAR_BITS_DEFAULT;
    localparam int YEAR_TOP   = (1 << YEAR_BITS) - 1;
    localparam int IDLE_PCT   = 23;
    localparam int DRAIN_WAIT = 2 * YEAR_BITS + 8;

    typedef struct packed {
        logic [DAY_BITS-1:0]   day;
        logic [MONTH_BITS-1:0] month;
        logic [YEAR_BITS-1:0]  year;
    } date_t;

    typedef struct packed {
        date_t earlier;
        date_t later;
    } date_pair_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] day_count;
        status_t               status;
    } span_t;

    logic clk;
    logic rst_n;
    bit   steady;
    int   hold_cycles;
    int   errors;

    span_t expected_spans[$];

    ddd_in_if #(.YEAR_BITS(YEAR_BITS)) req_ch ();
    ddd_out_if rsp_ch ();

    date_difference_days #(
        .YEAR_BITS(YEAR_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic bit gregorian_leap(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        int unsigned len;
        unique case (m)
            2:          len = gregorian_leap(y) ? 29 : 28;
            4, 6, 9, 11: len = 30;
            default:    len = 31;
        endcase
        return len;
    endfunction

    function automatic bit date_ok(date_t d);
        if (d.month < 1 || d.month > MONTHS || d.year == 0 || d.day == 0)
            return 1'b0;
        return d.day <= days_in_month(32'(d.month), 32'(d.year));
    endfunction

    // days since the first day of year 1
    function automatic longint unsigned day_number(date_t d);
        longint unsigned p;
        longint unsigned n;
        p = 64'(d.year) - 64'd1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < d.month; k++)
            n += 64'(days_in_month(k, 32'(d.year)));
        return n + 64'(d.day) - 64'd1;
    endfunction

    function automatic span_t predict_span(date_pair_t q);
        span_t           r;
        longint unsigned a;
        longint unsigned b;
        r.day_count = '0;
        r.status    = STATUS_OK;
        if (!date_ok(q.earlier) || !date_ok(q.later))
        begin
            r.status = STATUS_INVALID;
        end
        else
        begin
            a = day_number(q.earlier);
            b = day_number(q.later);
            if (a > b)
                r.status = STATUS_ORDER;
            else if (b - a > COUNT_MAX)
                r.day_count = COUNT_MAX;
            else
                r.day_count = COUNT_BITS'(b - a);
        end
        return r;
    endfunction

    function automatic date_pair_t pair_of(int unsigned ed, int unsigned em, int unsigned ey,
                                           int unsigned ld, int unsigned lm, int unsigned ly);
        date_pair_t q;
        q.earlier.day   = DAY_BITS'(ed);
        q.earlier.month = MONTH_BITS'(em);
        q.earlier.year  = YEAR_BITS'(ey);
        q.later.day     = DAY_BITS'(ld);
        q.later.month   = MONTH_BITS'(lm);
        q.later.year    = YEAR_BITS'(ly);
        return q;
    endfunction

    function automatic date_t random_valid(int unsigned y);
        date_t d;
        d.year  = YEAR_BITS'(y);
        d.month = MONTH_BITS'($urandom_range(1, MONTHS));
        d.day   = DAY_BITS'($urandom_range(1, days_in_month(32'(d.month), y)));
        return d;
    endfunction

    task automatic send_dates(date_pair_t q);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid         <= 1'b1;
        req_ch.earlier_day   <= q.earlier.day;
        req_ch.earlier_month <= q.earlier.month;
        req_ch.earlier_year  <= q.earlier.year;
        req_ch.later_day     <= q.later.day;
        req_ch.later_month   <= q.later.month;
        req_ch.later_year    <= q.later.year;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_spans.push_back(predict_span(q));
    endtask

    task automatic drain;
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_spans.size() != 0)
            @(posedge clk);
    endtask

    // hold ready low on request, otherwise idle at random unless steady is set
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_cycles--;
        end
        else
        begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        span_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_spans.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got day_count %0d status %0d",
                         $time, rsp_ch.day_count, rsp_ch.status);
                errors++;
            end
            else
            begin
                want = expected_spans.pop_front();
                if (rsp_ch.day_count !== want.day_count)
                begin
                    $display("%0t: day_count mismatch: expected %0d, got %0d",
                             $time, want.day_count, rsp_ch.day_count);
                    errors++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, rsp_ch.status);
                    errors++;
                end
            end
        end
    end

    task automatic test_equal_and_adjacent;
        send_dates(pair_of(1, 1, 1, 1, 1, 1));
        send_dates(pair_of(31, 12, 1999, 1, 1, 2000));
        send_dates(pair_of(28, 2, 2023, 1, 3, 2023));
        send_dates(pair_of(1, 1, 2024, 31, 12, 2024));
    endtask

    task automatic test_leap_rule;
        send_dates(pair_of(28, 2, 2000, 1, 3, 2000));
        send_dates(pair_of(29, 2, 2000, 29, 2, 2004));
        send_dates(pair_of(28, 2, 1900, 1, 3, 1900));
        send_dates(pair_of(29, 2, 1900, 1, 3, 1900));
        send_dates(pair_of(1, 1, 2001, 29, 2, 2001));
        send_dates(pair_of(1, 1, 1600, 1, 1, 2000));
    endtask

    task automatic test_invalid_dates;
        send_dates(pair_of(1, 0, 2000, 1, 1, 2001));
        send_dates(pair_of(1, 1, 2000, 1, 13, 2001));
        send_dates(pair_of(10, 15, 2000, 1, 1, 2001));
        send_dates(pair_of(0, 5, 2000, 1, 6, 2000));
        send_dates(pair_of(31, 4, 2000, 1, 6, 2000));
        send_dates(pair_of(1, 1, 1, 1, 1, 0));
        send_dates(pair_of(31, 11, 3000, 1, 1, 10));
    endtask

    task automatic test_wrong_order;
        send_dates(pair_of(1, 1, 2001, 31, 12, 2000));
        send_dates(pair_of(1, 8, 2010, 31, 7, 2010));
        send_dates(pair_of(16, 3, 42, 15, 3, 42));
    endtask

    task automatic test_extremes;
        send_dates(pair_of(1, 1, 1, 31, 12, YEAR_TOP));
        send_dates(pair_of(31, 12, YEAR_TOP, 31, 12, YEAR_TOP));
        send_dates(pair_of(31, 15, YEAR_TOP, 31, 15, YEAR_TOP));
        send_dates(pair_of(31, 1, YEAR_TOP, 1, 1, 1));
    endtask

    task automatic test_backpressure;
        steady      = 1'b1;
        hold_cycles = 400;
        for (int i = 0; i < 6; i++)
            send_dates(pair_of(1, 1, 1000 + i, $urandom_range(1, 28), 2, 1000 + i));
        steady = 1'b0;
        drain();
    endtask

    task automatic test_random_dates;
        date_pair_t  q;
        date_t       t;
        int unsigned kind;
        int unsigned sel;
        int unsigned yspan;
        int unsigned ey;
        for (int i = 0; i < 110; i++)
        begin
            steady = (i >= 50 && i < 90);
            kind   = $urandom_range(0, 99);
            if (kind < 12)
            begin
                q = pair_of($urandom_range(0, 31), $urandom_range(0, 15),
                            $urandom_range(0, YEAR_TOP), $urandom_range(0, 31),
                            $urandom_range(0, 15), $urandom_range(0, YEAR_TOP));
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                    yspan = $urandom_range(0, YEAR_TOP - 1);
                else if (sel < 40)
                    yspan = 0;
                else
                    yspan = $urandom_range(1, 12);
                ey        = $urandom_range(1, YEAR_TOP - yspan);
                q.earlier = random_valid(ey);
                q.later   = random_valid(ey + yspan);
                if (kind < 25)
                begin
                    t         = q.earlier;
                    q.earlier = q.later;
                    q.later   = t;
                end
            end
            send_dates(q);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        errors               = 0;
        steady               = 1'b0;
        hold_cycles          = 0;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.earlier_day   = '0;
        req_ch.earlier_month = '0;
        req_ch.earlier_year  = '0;
        req_ch.later_day     = '0;
        req_ch.later_month   = '0;
        req_ch.later_year    = '0;
        rsp_ch.ready         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_equal_and_adjacent();
        test_leap_rule();
        test_invalid_dates();
        test_wrong_order();
        test_extremes();
        test_backpressure();
        test_random_dates();

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("PASS date_difference_days");
        else
            $display("FAIL date_difference_days");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("FAIL date_difference_days");
        $finish;
    end

endmodule

`default_nettype wire
